>>> src/event_rule_matcher_assert.svh
// ----------------------------------------------------------------------------
// Event rule matcher assertion macros
// Shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef EVENT_RULE_MATCHER_ASSERT_SVH
`define EVENT_RULE_MATCHER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ERM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ERM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/erm_pkg.sv
// ----------------------------------------------------------------------------
// Event rule matcher package
// Field widths, rule word layout, action codes and register indexes.
// ----------------------------------------------------------------------------
package erm_pkg;

  localparam int unsigned RulesDefault = 16;

  localparam int unsigned ActionW  = 2;
  localparam int unsigned EvTypeW  = 8;
  localparam int unsigned IdW      = 16;
  localparam int unsigned ModsW    = 8;
  localparam int unsigned ButtonW  = 8;
  localparam int unsigned IndexW   = 4;
  localparam int unsigned TotalW   = 5;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 8;

  // Key word: keycode, node kind, presentation type, event type (msb to lsb).
  localparam int unsigned KeyW   = EvTypeW + 3 * IdW;
  // Extra word: command id, button, modifiers (msb to lsb).
  localparam int unsigned ExtraW = ModsW + ButtonW + IdW;

  typedef enum logic [ActionW-1:0] {
    ActMatch = 2'd0,
    ActAdd   = 2'd1,
    ActClear = 2'd2,
    ActRsvd  = 2'd3
  } action_e;

  localparam logic [CfgAddrW-1:0] CfgKeyDown  = 3'd0;
  localparam logic [CfgAddrW-1:0] CfgKeyUp    = 3'd1;
  localparam logic [CfgAddrW-1:0] CfgPtrDown  = 3'd2;
  localparam logic [CfgAddrW-1:0] CfgPtrUp    = 3'd3;
  localparam logic [CfgAddrW-1:0] CfgPtrMove  = 3'd4;

endpackage

>>> src/event_rule_matcher.sv
// ----------------------------------------------------------------------------
// Event rule matcher
// First-match table of event-to-command rules with wildcard fields.
//
// An input transaction carries an action: add a rule, clear the table, or
// match an event against the stored rules, scanned from index 0 upward.
// Every input transaction yields exactly one output transaction.
// Add, clear and reserved actions, and a match on an empty table, go from
// acceptance through the result state into the output register. A match
// reads one rule per cycle from the synchronous rule memory, stops at the
// first hit or after the last held rule, and then takes the same path.
// A new item is taken in the cycle after the previous result has moved
// into the output register, never while an item is still in progress.
// The output register holds a result while the receiver stalls; the next
// item may be accepted and processed meanwhile, and waits at its end for
// the output register to free up.
// Reset empties the table and clears the event type codes; the rule memory
// itself is not cleared. The codes are to be written through the plain
// configuration port while the block is idle; it does not enforce this.
// ----------------------------------------------------------------------------
module event_rule_matcher #(
  parameter int unsigned RULES = erm_pkg::RulesDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration port
  input  logic                          cfg_we_i,
  input  logic [erm_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [erm_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [erm_pkg::ActionW-1:0]   action_i,
  input  logic [erm_pkg::EvTypeW-1:0]   event_type_i,
  input  logic [erm_pkg::IdW-1:0]       pres_type_i,
  input  logic [erm_pkg::IdW-1:0]       node_kind_i,
  input  logic [erm_pkg::IdW-1:0]       keycode_i,
  input  logic [erm_pkg::ModsW-1:0]     mods_i,
  input  logic [erm_pkg::ButtonW-1:0]   button_i,
  input  logic [erm_pkg::IdW-1:0]       command_id_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          matched_o,
  output logic [erm_pkg::IndexW-1:0]    rule_index_o,
  output logic [erm_pkg::IdW-1:0]       command_out_o,
  output logic                          add_ok_o,
  output logic [erm_pkg::TotalW-1:0]    rule_total_o
);
  import erm_pkg::*;

  localparam int unsigned CntW   = $clog2(RULES + 1);
  localparam int unsigned AddrW  = (RULES > 1) ? $clog2(RULES) : 1;
  localparam int unsigned TotExW = (CntW > TotalW) ? CntW : TotalW;
  localparam int unsigned IdxExW = (AddrW > IndexW) ? AddrW : IndexW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESULT
  } state_e;

  state_e state_q;

  // Event type codes
  logic [CfgDataW-1:0] key_down_q, key_up_q, ptr_down_q, ptr_up_q, ptr_move_q;

  // Held input item
  logic [EvTypeW-1:0] ev_q;
  logic [IdW-1:0]     pt_q, nk_q, kc_q;
  logic [ModsW-1:0]   md_q;
  logic [ButtonW-1:0] bt_q;

  // Table and scan control
  logic [CntW-1:0]  count_q;
  logic [CntW-1:0]  idx_q;
  logic [CntW-1:0]  idx_nxt;

  // Pending result and output register
  logic             res_matched_q, res_add_ok_q;
  logic [AddrW-1:0] res_idx_q;
  logic [IdW-1:0]   res_cmd_q;
  logic             out_valid_q, out_matched_q, out_add_ok_q;
  logic [AddrW-1:0] out_idx_q;
  logic [IdW-1:0]   out_cmd_q;
  logic [CntW-1:0]  out_total_q;

  // Rule memories
  logic [KeyW-1:0]   keys_mem [RULES];
  logic [ExtraW-1:0] extra_mem [RULES];
  logic [KeyW-1:0]   keys_rd_q;
  logic [ExtraW-1:0] extra_rd_q;
  logic              mem_we;
  logic [AddrW-1:0]  wr_addr;
  logic [AddrW-1:0]  rd_addr;
  logic              table_full;

  logic              in_accept;
  logic [EvTypeW-1:0] r_ev;
  logic [IdW-1:0]     r_pt, r_nk, r_kc, r_cmd;
  logic [ModsW-1:0]   r_md;
  logic [ButtonW-1:0] r_bt;
  logic               is_key, is_ptr, hit;

  logic [TotExW-1:0] total_ext;
  logic [IdxExW-1:0] index_ext;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_accept  = in_valid_i & in_ready_o;
  assign table_full = (count_q >= CntW'(RULES));
  assign mem_we     = in_accept & (action_i == ActAdd) & ~table_full;
  assign wr_addr    = count_q[AddrW-1:0];
  assign idx_nxt    = idx_q + 1'b1;
  // The address-zero read issued while idle is what the first scan cycle sees.
  assign rd_addr    = (state_q == S_SCAN) ? idx_nxt[AddrW-1:0] : '0;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      keys_mem[wr_addr]  <= {keycode_i, node_kind_i, pres_type_i, event_type_i};
      extra_mem[wr_addr] <= {command_id_i, button_i, mods_i};
    end
    keys_rd_q  <= keys_mem[rd_addr];
    extra_rd_q <= extra_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      ev_q <= event_type_i;
      pt_q <= pres_type_i;
      nk_q <= node_kind_i;
      kc_q <= keycode_i;
      md_q <= mods_i;
      bt_q <= button_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_down_q <= '0;
      key_up_q   <= '0;
      ptr_down_q <= '0;
      ptr_up_q   <= '0;
      ptr_move_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CfgKeyDown: key_down_q <= cfg_wdata_i;
        CfgKeyUp:   key_up_q   <= cfg_wdata_i;
        CfgPtrDown: ptr_down_q <= cfg_wdata_i;
        CfgPtrUp:   ptr_up_q   <= cfg_wdata_i;
        CfgPtrMove: ptr_move_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Rule comparison against the entry read in the previous cycle.
  assign r_ev  = keys_rd_q[EvTypeW-1:0];
  assign r_pt  = keys_rd_q[EvTypeW +: IdW];
  assign r_nk  = keys_rd_q[EvTypeW + IdW +: IdW];
  assign r_kc  = keys_rd_q[EvTypeW + 2 * IdW +: IdW];
  assign r_md  = extra_rd_q[ModsW-1:0];
  assign r_bt  = extra_rd_q[ModsW +: ButtonW];
  assign r_cmd = extra_rd_q[ModsW + ButtonW +: IdW];

  assign is_key = (ev_q == key_down_q) | (ev_q == key_up_q);
  assign is_ptr = (ev_q == ptr_down_q) | (ev_q == ptr_up_q) | (ev_q == ptr_move_q);

  always_comb begin
    hit = 1'b1;
    if ((r_ev != '0) && (r_ev != ev_q)) hit = 1'b0;
    if ((r_pt != '0) && (r_pt != pt_q)) hit = 1'b0;
    if ((r_nk != '0) && (r_nk != nk_q)) hit = 1'b0;
    if ((r_kc != '0) && (!is_key || (kc_q != r_kc) || (md_q != r_md))) hit = 1'b0;
    if ((r_bt != '0) && (!is_ptr || (bt_q != r_bt) || (md_q != r_md))) hit = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      count_q       <= '0;
      idx_q         <= '0;
      res_matched_q <= 1'b0;
      res_add_ok_q  <= 1'b0;
      res_idx_q     <= '0;
      res_cmd_q     <= '0;
      out_valid_q   <= 1'b0;
      out_matched_q <= 1'b0;
      out_add_ok_q  <= 1'b0;
      out_idx_q     <= '0;
      out_cmd_q     <= '0;
      out_total_q   <= '0;
    end else begin
      // While a result is pending, the result state alone updates the valid flag.
      if (out_ready_i && (state_q != S_RESULT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            res_matched_q <= 1'b0;
            res_add_ok_q  <= 1'b0;
            res_idx_q     <= '0;
            res_cmd_q     <= '0;
            idx_q         <= '0;
            state_q       <= S_RESULT;
            case (action_e'(action_i))
              ActMatch: begin
                if (count_q != '0) begin
                  state_q <= S_SCAN;
                end
              end
              ActAdd: begin
                if (!table_full) begin
                  count_q      <= count_q + 1'b1;
                  res_add_ok_q <= 1'b1;
                end
              end
              ActClear: count_q <= '0;
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          if (hit) begin
            res_matched_q <= 1'b1;
            res_idx_q     <= idx_q[AddrW-1:0];
            res_cmd_q     <= r_cmd;
            state_q       <= S_RESULT;
          end else if (idx_nxt == count_q) begin
            state_q <= S_RESULT;
          end else begin
            idx_q <= idx_nxt;
          end
        end
        S_RESULT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q   <= 1'b1;
            out_matched_q <= res_matched_q;
            out_add_ok_q  <= res_add_ok_q;
            out_idx_q     <= res_idx_q;
            out_cmd_q     <= res_cmd_q;
            out_total_q   <= count_q;
            state_q       <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign total_ext = TotExW'(out_total_q);
  assign index_ext = IdxExW'(out_idx_q);

  assign out_valid_o   = out_valid_q;
  assign matched_o     = out_matched_q;
  assign add_ok_o      = out_add_ok_q;
  assign command_out_o = out_cmd_q;
  assign rule_index_o  = index_ext[IndexW-1:0];
  assign rule_total_o  = total_ext[TotalW-1:0];

  `include "event_rule_matcher_assert.svh"

  `ERM_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CntW'(RULES), "rule count above table size")
  `ERM_ASSERT_IMP(a_scan_in_table, state_q == S_SCAN, idx_q < count_q, "scan beyond held rules")
  `ERM_ASSERT_NXT(a_add_grows, mem_we, count_q == $past(count_q) + 1'b1, "add did not grow table")
  `ERM_ASSERT_IMP(a_match_not_add, out_valid_o && matched_o, !add_ok_o, "match and add both flagged")

endmodule
